/* design/chd_pkg.sv */
// ----------------------------------------------------------------------------
// chd_pkg: shared definitions for the chunked body decoder
// Item types, parser phases, character codes and the character classifiers.
// ----------------------------------------------------------------------------
package chd_pkg;

	localparam int SIZE_BITS_DEF = 32;

	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_SP   = 8'h20;
	localparam logic [7:0] CHAR_TAB  = 8'h09;
	localparam logic [7:0] CHAR_VT   = 8'h0B;
	localparam logic [7:0] CHAR_FF   = 8'h0C;
	localparam logic [7:0] CHAR_0    = 8'h30;
	localparam logic [7:0] CHAR_9    = 8'h39;
	localparam logic [7:0] CHAR_LA   = 8'h61;
	localparam logic [7:0] CHAR_LF_X = 8'h66;
	localparam logic [7:0] CHAR_UA   = 8'h41;
	localparam logic [7:0] CHAR_UF   = 8'h46;
	localparam logic [7:0] HEX_TEN   = 8'd10;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [2:0] {
		PH_LEAD    = 3'd0,
		PH_DIGITS  = 3'd1,
		PH_DATA    = 3'd2,
		PH_GAP     = 3'd3,
		PH_TRAILER = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       new_body;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic       chunk_last;
		logic       size_saturated;
	} out_item_t;

	// Contents of the input register as seen by the parser.
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} stage_t;

	// Hex digit decode: bit 4 set when the character is a hex digit.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			v = c - CHAR_0;
			return {1'b1, v[3:0]};
		end else if (c >= CHAR_LA && c <= CHAR_LF_X) begin
			v = c - CHAR_LA + HEX_TEN;
			return {1'b1, v[3:0]};
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			v = c - CHAR_UA + HEX_TEN;
			return {1'b1, v[3:0]};
		end
		return 5'd0;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CHAR_SP) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
	endfunction

endpackage

/* design/chd_stream_if.sv */
// ----------------------------------------------------------------------------
// chd_stream_if: valid/ready stream channel
// Carries one item per handshake; the source drives valid and data.
// ----------------------------------------------------------------------------
interface chd_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/chd_in_stage.sv */
// ----------------------------------------------------------------------------
// chd_in_stage: input register
// Captures one body byte per cycle while the parser takes them, and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module chd_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	chd_stream_if.sink       body,
	input  logic             take,
	output chd_pkg::stage_t  stage
);
	import chd_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	assign body.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.ready && body.valid) begin
			item_s1 <= body.data;
		end
	end

	assign stage = '{valid: valid_s1, item: item_s1};
endmodule

/* design/chd_parser.sv */
// ----------------------------------------------------------------------------
// chd_parser: chunk framing state and result register
// Updates the framing state from one byte and registers any result item.
// ----------------------------------------------------------------------------
module chd_parser #(
	parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  chd_pkg::stage_t stage,
	output logic            take,
	chd_stream_if.source    payload
);
	import chd_pkg::*;

	phase_t               phase_q, phase_d, ph_e;
	logic [SIZE_BITS-1:0] remain_q, remain_d, rem_e, rem_dec;
	logic                 dig_end_q, dig_end_d, dig_e;
	logic                 gap_q, gap_d, gap_e;
	logic                 trail_q, trail_d, trail_e;
	logic                 ovf_q, ovf_d, ovf_e;
	logic                 res_valid;
	out_item_t            res;
	logic                 out_valid_q;
	out_item_t            out_item_q;
	logic [7:0]           c;
	logic [4:0]           hex;
	logic                 fire;

	assign take = !out_valid_q || payload.ready;
	assign fire = stage.valid && take;
	assign c    = stage.item.in_byte;
	assign hex  = hex_decode(c);

	always_comb begin
		// A new body starts from the reset state before this byte.
		if (stage.item.new_body) begin
			ph_e    = PH_LEAD;
			rem_e   = '0;
			dig_e   = 1'b0;
			gap_e   = 1'b0;
			trail_e = 1'b0;
			ovf_e   = 1'b0;
		end else begin
			ph_e    = phase_q;
			rem_e   = remain_q;
			dig_e   = dig_end_q;
			gap_e   = gap_q;
			trail_e = trail_q;
			ovf_e   = ovf_q;
		end

		phase_d   = ph_e;
		remain_d  = rem_e;
		dig_end_d = dig_e;
		gap_d     = gap_e;
		trail_d   = trail_e;
		ovf_d     = ovf_e;
		rem_dec   = rem_e - {{(SIZE_BITS-1){1'b0}}, 1'b1};
		res_valid = 1'b0;
		res       = '{kind: KIND_DATA, out_byte: 8'd0, chunk_last: 1'b0,
			size_saturated: 1'b0};

		case (ph_e)
			PH_LEAD, PH_DIGITS: begin
				if (c == CHAR_LF) begin
					if (rem_e != '0) begin
						phase_d = PH_DATA;
					end else begin
						phase_d = PH_TRAILER;
						trail_d = 1'b0;
					end
				end else if (c == CHAR_CR || dig_e) begin
					phase_d = ph_e;
				end else if (ph_e == PH_LEAD && is_blank(c)) begin
					phase_d = ph_e;
				end else if (hex[4]) begin
					phase_d = PH_DIGITS;
					if (ovf_e || rem_e[SIZE_BITS-1 -: 4] != 4'd0) begin
						remain_d = '1;
						ovf_d    = 1'b1;
					end else begin
						remain_d = {rem_e[SIZE_BITS-5:0], hex[3:0]};
					end
				end else begin
					dig_end_d = 1'b1;
					phase_d   = PH_DIGITS;
				end
			end
			PH_DATA: begin
				remain_d  = rem_dec;
				res_valid = 1'b1;
				res       = '{kind: KIND_DATA, out_byte: c,
					chunk_last: (rem_dec == '0), size_saturated: ovf_e};
				if (rem_dec == '0) begin
					phase_d = PH_GAP;
					gap_d   = 1'b0;
				end
			end
			PH_GAP: begin
				if (!gap_e) begin
					gap_d = 1'b1;
				end else begin
					phase_d   = PH_LEAD;
					remain_d  = '0;
					dig_end_d = 1'b0;
					gap_d     = 1'b0;
					trail_d   = 1'b0;
					ovf_d     = 1'b0;
				end
			end
			PH_TRAILER: begin
				if (c == CHAR_LF) begin
					if (!trail_e) begin
						phase_d   = PH_DONE;
						res_valid = 1'b1;
						res       = '{kind: KIND_END, out_byte: 8'd0,
							chunk_last: 1'b0, size_saturated: 1'b0};
					end else begin
						trail_d = 1'b0;
					end
				end else if (c != CHAR_CR) begin
					trail_d = 1'b1;
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEAD;
			remain_q  <= '0;
			dig_end_q <= 1'b0;
			gap_q     <= 1'b0;
			trail_q   <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_d;
			remain_q  <= remain_d;
			dig_end_q <= dig_end_d;
			gap_q     <= gap_d;
			trail_q   <= trail_d;
			ovf_q     <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= res_valid;
		end else if (payload.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_item_q <= res;
		end
	end

	assign payload.valid = out_valid_q;
	assign payload.data  = out_item_q;
endmodule

/* design/http_chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer decoder
// Strips chunk framing from a response body and delivers the payload bytes.
//
// Feed the body one byte per item on the body channel; set new_body on the
// first byte of each body. Payload bytes come out on the payload channel with
// kind 0, chunk_last on the final byte of each chunk and size_saturated when
// the chunk size field overflowed SIZE_BITS bits and was clamped to all ones.
// After the zero-size chunk and its trailer lines, one item with kind 1 marks
// the end of the body; further bytes are dropped until new_body is set. Size
// lines, CR, the two bytes after each chunk and trailer bytes produce no item.
// The decoder takes one byte every cycle unless a result waits untaken: a
// byte passes an input register, then the framing state update and the
// result register, which offers the result until the payload channel takes
// it. While a result waits untaken, the parser stalls and the input register
// holds the next byte; the state update runs once per byte.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
	parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	chd_stream_if.sink   body,
	chd_stream_if.source payload
);
	import chd_pkg::*;

	stage_t stage;
	logic   take;

	// Input register: holds one byte until the parser consumes it.
	chd_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body),
		.take   (take),
		.stage  (stage)
	);

	// Framing state and result register.
	chd_parser #(
		.SIZE_BITS (SIZE_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.take    (take),
		.payload (payload)
	);
endmodule
